/* src/jss_pkg.sv */
package jss_pkg;

	// Command codes carried in s_tuser.
	localparam logic [2:0] CMD_RESET = 3'd0;
	localparam logic [2:0] CMD_IDLE  = 3'd1;
	localparam logic [2:0] CMD_IR    = 3'd2;
	localparam logic [2:0] CMD_DR    = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	localparam int unsigned IR_LEAD_LEN  = 4;
	localparam int unsigned IR_LEAD_ONES = 2;
	localparam int unsigned DR_LEAD_LEN  = 3;
	localparam int unsigned DR_LEAD_ONES = 1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_HI,
		PH_RST_LO,
		PH_RUN,
		PH_IR_PRE,
		PH_DR_PRE,
		PH_SHIFT,
		PH_POST1,
		PH_POST2
	} phase_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  bit_count;
		logic [31:0] shift_data;
		logic [15:0] expected_data;
		logic        check_enable;
		logic        tdo_bit;
	} item_t;

	typedef struct packed {
		logic        pulse_valid;
		logic        tms_level;
		logic        tdi_level;
		logic        sequence_done;
		logic [15:0] captured_word;
		logic        compare_mismatch;
		logic        command_rejected;
	} result_t;

endpackage

/* src/jss_engine.sv */
module jss_engine #(
	parameter int unsigned RESET_PULSES   = 64,
	parameter int unsigned CAPTURE_WIDTH  = 16,
	parameter int unsigned MAX_SHIFT_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  jss_pkg::item_t  item,
	output jss_pkg::result_t result
);

	localparam int unsigned BW = $clog2(MAX_SHIFT_BITS + 1);
	localparam int unsigned CMPW = (CAPTURE_WIDTH > 16) ? CAPTURE_WIDTH : 16;

	jss_pkg::phase_t phase_q, phase_d;
	logic [7:0]               cnt_q, cnt_d;
	logic [BW-1:0]            bits_q, bits_d;
	logic [31:0]              shift_q, shift_d;
	logic [CAPTURE_WIDTH-1:0] cap_q, cap_d;
	logic                     tms_q, tms_d;
	logic                     tdi_q, tdi_d;
	logic [15:0]              exp_q, exp_d;
	logic                     chk_q, chk_d;

	logic       is_cmd, is_tick, idle;
	logic [7:0] cnt_inc, cnt_dec;

	assign is_cmd  = item.command inside {[jss_pkg::CMD_RESET : jss_pkg::CMD_DR]};
	assign is_tick = (item.command == jss_pkg::CMD_TICK);
	assign idle    = (phase_q == jss_pkg::PH_IDLE);
	assign cnt_inc = cnt_q + 8'd1;
	assign cnt_dec = cnt_q - 8'd1;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (is_cmd && idle) begin
			case (item.command)
				jss_pkg::CMD_RESET: phase_d = jss_pkg::PH_RST_HI;
				jss_pkg::CMD_IDLE: begin
					if (item.bit_count != 8'd0) phase_d = jss_pkg::PH_RUN;
				end
				jss_pkg::CMD_IR: phase_d = jss_pkg::PH_IR_PRE;
				default:         phase_d = jss_pkg::PH_DR_PRE;
			endcase
		end else if (is_tick) begin
			case (phase_q)
				jss_pkg::PH_IDLE: phase_d = jss_pkg::PH_IDLE;
				jss_pkg::PH_RST_HI: begin
					if (cnt_inc >= 8'(RESET_PULSES)) phase_d = jss_pkg::PH_RST_LO;
				end
				jss_pkg::PH_RST_LO: phase_d = jss_pkg::PH_IDLE;
				jss_pkg::PH_RUN: begin
					if (cnt_dec == 8'd0) phase_d = jss_pkg::PH_IDLE;
				end
				jss_pkg::PH_IR_PRE: begin
					if (cnt_inc >= 8'(jss_pkg::IR_LEAD_LEN))
						phase_d = (bits_q != '0) ? jss_pkg::PH_SHIFT : jss_pkg::PH_POST1;
				end
				jss_pkg::PH_DR_PRE: begin
					if (cnt_inc >= 8'(jss_pkg::DR_LEAD_LEN))
						phase_d = (bits_q != '0) ? jss_pkg::PH_SHIFT : jss_pkg::PH_POST1;
				end
				jss_pkg::PH_SHIFT: begin
					if (bits_q == BW'(1)) phase_d = jss_pkg::PH_POST1;
				end
				jss_pkg::PH_POST1: phase_d = jss_pkg::PH_POST2;
				default:           phase_d = jss_pkg::PH_IDLE;
			endcase
		end
	end

	// Datapath registers and the result word.
	always_comb begin
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		cap_d   = cap_q;
		tms_d   = tms_q;
		tdi_d   = tdi_q;
		exp_d   = exp_q;
		chk_d   = chk_q;
		result  = '0;

		if (is_cmd) begin
			if (!idle) begin
				result.command_rejected = 1'b1;
			end else begin
				case (item.command)
					jss_pkg::CMD_RESET: cnt_d = 8'd0;
					jss_pkg::CMD_IDLE: begin
						if (item.bit_count != 8'd0) cnt_d = item.bit_count;
					end
					default: begin
						cnt_d   = 8'd0;
						bits_d  = (item.bit_count > 8'(MAX_SHIFT_BITS)) ?
						          BW'(MAX_SHIFT_BITS) : BW'(item.bit_count);
						shift_d = item.shift_data;
						cap_d   = '0;
						exp_d   = item.expected_data;
						chk_d   = (item.command == jss_pkg::CMD_DR) && item.check_enable;
					end
				endcase
			end
		end else if (is_tick && !idle) begin
			result.pulse_valid = 1'b1;
			case (phase_q)
				jss_pkg::PH_RST_HI: begin
					tms_d = 1'b1;
					tdi_d = 1'b1;
					cnt_d = cnt_inc;
				end
				jss_pkg::PH_RST_LO: begin
					tms_d = 1'b0;
					result.sequence_done = 1'b1;
				end
				jss_pkg::PH_RUN: begin
					cnt_d = cnt_dec;
					result.sequence_done = (cnt_dec == 8'd0);
				end
				jss_pkg::PH_IR_PRE: begin
					tms_d = (cnt_q < 8'(jss_pkg::IR_LEAD_ONES));
					cnt_d = cnt_inc;
				end
				jss_pkg::PH_DR_PRE: begin
					tms_d = (cnt_q < 8'(jss_pkg::DR_LEAD_ONES));
					cnt_d = cnt_inc;
				end
				jss_pkg::PH_SHIFT: begin
					tdi_d   = shift_q[0];
					shift_d = {1'b0, shift_q[31:1]};
					if (bits_q == BW'(1)) tms_d = 1'b1;
					cap_d   = {item.tdo_bit, cap_q[CAPTURE_WIDTH-1:1]};
					bits_d  = bits_q - BW'(1);
				end
				jss_pkg::PH_POST1: tdi_d = 1'b0;
				default: begin
					tdi_d = 1'b0;
					tms_d = 1'b0;
					result.sequence_done    = 1'b1;
					result.compare_mismatch = chk_q && (CMPW'(cap_q) != CMPW'(exp_q));
				end
			endcase
		end

		result.tms_level     = tms_d;
		result.tdi_level     = tdi_d;
		result.captured_word = 16'(cap_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jss_pkg::PH_IDLE;
			cnt_q   <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			cap_q   <= '0;
			tms_q   <= 1'b0;
			tdi_q   <= 1'b0;
			exp_q   <= '0;
			chk_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			cap_q   <= cap_d;
			tms_q   <= tms_d;
			tdi_q   <= tdi_d;
			exp_q   <= exp_d;
			chk_q   <= chk_d;
		end
	end

endmodule

/* src/jtag_scan_sequencer_core.sv */
// Channel  | Signals                        | Direction | Contents
// ---------+--------------------------------+-----------+---------------------------------
// s_axis   | s_tvalid s_tready s_tdata/user | in        | one command or tick word
// m_axis   | m_tvalid m_tready m_tdata/last | out       | one pulse result word per input
//
// One word is accepted per cycle while s_tready is high; each accepted word is held in the
// input register, and its result, set by the single sequencer step, then enters the result register.
// arst_n returns the sequencer to idle with TMS/TDI low and the capture cleared.
// With m_tready low the result register holds its word and the input register
// still takes one more word before s_tready drops.
module jtag_scan_sequencer_core #(
	parameter int unsigned RESET_PULSES   = 64,
	parameter int unsigned CAPTURE_WIDTH  = 16,
	parameter int unsigned MAX_SHIFT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // bit_count, shift_data, expected_data, check_enable, tdo_bit
	input  logic [2:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // pulse_valid, tms_level, tdi_level, captured_word,
	                              // compare_mismatch, command_rejected
	output logic        m_tlast   // sequence_done
);

	jss_pkg::item_t   item_s1;
	logic             valid_s1;
	jss_pkg::result_t res_d, res_q;
	logic             out_valid_q;
	logic             fire;

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command       <= s_tuser;
			item_s1.bit_count     <= s_tdata[7:0];
			item_s1.shift_data    <= s_tdata[39:8];
			item_s1.expected_data <= s_tdata[55:40];
			item_s1.check_enable  <= s_tdata[56];
			item_s1.tdo_bit       <= s_tdata[57];
		end
	end

	jss_engine #(
		.RESET_PULSES   (RESET_PULSES),
		.CAPTURE_WIDTH  (CAPTURE_WIDTH),
		.MAX_SHIFT_BITS (MAX_SHIFT_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.sequence_done;
	assign m_tdata  = {3'b000, res_q.command_rejected, res_q.compare_mismatch,
	                   res_q.captured_word, res_q.tdi_level, res_q.tms_level,
	                   res_q.pulse_valid};

endmodule

/* src/jss_checker.sv */
module jss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// An offered input word stays put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input word changed while stalled");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// A rejected command never makes a pulse.
	a_reject_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> !m_tdata[0] && !m_tlast)
		else $error("rejected command produced a pulse");

	// The end of a sequence is always a real pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[0])
		else $error("sequence end without a pulse");

	// A compare mismatch is only reported on the closing pulse.
	a_mism_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19] |-> m_tlast && !m_tdata[1] && !m_tdata[2])
		else $error("mismatch outside the closing pulse");

endmodule

bind jtag_scan_sequencer_core jss_checker u_jss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int RESET_LEN = 64;
	localparam int SHIFT_MAX = 32;
	localparam int WORD_GOAL = 1350;
	localparam logic [2:0] CMD_BAD_FIRST = 3'd5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [2:0]  s_tuser = jss_pkg::CMD_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	// Predicted sequencer state, updated as each word is accepted.
	jss_pkg::phase_t ph = jss_pkg::PH_IDLE;
	logic [7:0]  pulse_cnt = '0;
	logic [5:0]  bits_rem = '0;
	logic [31:0] tdi_shift = '0;
	logic [15:0] cap = '0;
	logic        tms_r = 1'b0;
	logic        tdi_r = 1'b0;
	logic [15:0] exp_r = '0;
	logic        chk_r = 1'b0;

	jss_pkg::result_t pulse_expect_q[$];
	int      errors = 0;
	int      words_sent = 0;
	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;
	int      rx_hold_req = 0;
	int      rx_hold_left = 0;
	int      rx_gap_left = 0;

	jtag_scan_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic jss_pkg::result_t predict_pulse(input jss_pkg::item_t it);
		jss_pkg::result_t r;
		int      lead_len;
		int      lead_ones;
		r = '0;
		if (it.command <= jss_pkg::CMD_DR) begin
			if (ph != jss_pkg::PH_IDLE) begin
				r.command_rejected = 1'b1;
			end else if (it.command == jss_pkg::CMD_RESET) begin
				ph = jss_pkg::PH_RST_HI;
				pulse_cnt = '0;
			end else if (it.command == jss_pkg::CMD_IDLE) begin
				if (it.bit_count != 0) begin
					ph = jss_pkg::PH_RUN;
					pulse_cnt = it.bit_count;
				end
			end else begin
				ph = (it.command == jss_pkg::CMD_IR) ? jss_pkg::PH_IR_PRE : jss_pkg::PH_DR_PRE;
				pulse_cnt = '0;
				bits_rem = (it.bit_count > SHIFT_MAX) ? 6'(SHIFT_MAX) : 6'(it.bit_count);
				tdi_shift = it.shift_data;
				cap = '0;
				exp_r = it.expected_data;
				chk_r = (it.command == jss_pkg::CMD_DR) ? it.check_enable : 1'b0;
			end
		end else if (it.command == jss_pkg::CMD_TICK && ph != jss_pkg::PH_IDLE) begin
			r.pulse_valid = 1'b1;
			case (ph)
				jss_pkg::PH_RST_HI: begin
					tms_r = 1'b1;
					tdi_r = 1'b1;
					pulse_cnt = pulse_cnt + 8'd1;
					if (pulse_cnt >= RESET_LEN)
						ph = jss_pkg::PH_RST_LO;
				end
				jss_pkg::PH_RST_LO: begin
					tms_r = 1'b0;
					r.sequence_done = 1'b1;
					ph = jss_pkg::PH_IDLE;
				end
				jss_pkg::PH_RUN: begin
					pulse_cnt = pulse_cnt - 8'd1;
					if (pulse_cnt == 0) begin
						r.sequence_done = 1'b1;
						ph = jss_pkg::PH_IDLE;
					end
				end
				jss_pkg::PH_IR_PRE, jss_pkg::PH_DR_PRE: begin
					lead_len = (ph == jss_pkg::PH_IR_PRE) ? jss_pkg::IR_LEAD_LEN :
						jss_pkg::DR_LEAD_LEN;
					lead_ones = (ph == jss_pkg::PH_IR_PRE) ? jss_pkg::IR_LEAD_ONES :
						jss_pkg::DR_LEAD_ONES;
					tms_r = (pulse_cnt < lead_ones);
					pulse_cnt = pulse_cnt + 8'd1;
					if (pulse_cnt >= lead_len)
						ph = (bits_rem != 0) ? jss_pkg::PH_SHIFT : jss_pkg::PH_POST1;
				end
				jss_pkg::PH_SHIFT: begin
					tdi_r = tdi_shift[0];
					tdi_shift = tdi_shift >> 1;
					if (bits_rem == 1)
						tms_r = 1'b1;
					cap = {it.tdo_bit, cap[15:1]};
					bits_rem = bits_rem - 6'd1;
					if (bits_rem == 0)
						ph = jss_pkg::PH_POST1;
				end
				jss_pkg::PH_POST1: begin
					tdi_r = 1'b0;
					ph = jss_pkg::PH_POST2;
				end
				default: begin
					tdi_r = 1'b0;
					tms_r = 1'b0;
					r.sequence_done = 1'b1;
					r.compare_mismatch = chk_r && (cap != exp_r);
					ph = jss_pkg::PH_IDLE;
				end
			endcase
		end
		r.tms_level = tms_r;
		r.tdi_level = tdi_r;
		r.captured_word = cap;
		return r;
	endfunction

	task automatic send_word(input logic [2:0] cmd, input logic [7:0] cnt,
			input logic [31:0] data, input logic [15:0] expd, input logic chk,
			input logic tdo);
		jss_pkg::item_t it;
		int    gap;
		it = '{command: cmd, bit_count: cnt, shift_data: data, expected_data: expd,
			check_enable: chk, tdo_bit: tdo};
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, it.tdo_bit, it.check_enable, it.expected_data, it.shift_data,
			it.bit_count};
		s_tuser <= it.command;
		do
			@(posedge clk);
		while (!s_tready);
		pulse_expect_q.push_back(predict_pulse(it));
		words_sent++;
	endtask

	task automatic send_tick(input logic tdo);
		send_word(jss_pkg::CMD_TICK, 8'($urandom), $urandom, 16'($urandom), 1'($urandom),
			tdo);
	endtask

	// While busy any command is refused; while idle only ticks and unused codes
	// are harmless.
	task automatic send_stray();
		logic [2:0] cmd;
		if (ph != jss_pkg::PH_IDLE)
			cmd = 3'($urandom_range(0, 3));
		else
			cmd = jss_pkg::CMD_TICK;
		if ($urandom_range(0, 1) == 0)
			cmd = CMD_BAD_FIRST + 3'($urandom_range(0, 2));
		send_word(cmd, 8'($urandom), $urandom, 16'($urandom), 1'($urandom),
			1'($urandom));
	endtask

	// Issues one command and ticks it to completion. TDO bits on the shift
	// pulses come from a pattern so that a matching compare value can be set.
	task automatic run_sequence(input logic [2:0] cmd, input logic [7:0] cnt,
			input logic [31:0] data, input logic [15:0] expd, input logic chk,
			input bit want_match, input int noise_pct);
		logic [31:0] tdo_pat;
		logic [15:0] fold;
		int          n;
		tdo_pat = $urandom;
		if (want_match) begin
			n = (cnt > SHIFT_MAX) ? SHIFT_MAX : cnt;
			fold = '0;
			for (int i = 0; i < n; i++)
				fold = {tdo_pat[i], fold[15:1]};
			expd = fold;
		end
		send_word(cmd, cnt, data, expd, chk, 1'($urandom));
		while (ph != jss_pkg::PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_stray();
			end else if (ph == jss_pkg::PH_SHIFT) begin
				send_tick(tdo_pat[0]);
				tdo_pat = tdo_pat >> 1;
			end else begin
				send_tick(1'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pulse_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_tick(1'b1);
		for (int k = 0; k < 3; k++)
			send_word(CMD_BAD_FIRST + 3'(k), 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
		run_sequence(jss_pkg::CMD_IDLE, 8'd0, '0, '0, 1'b0, 1'b0, 0);
		run_sequence(jss_pkg::CMD_IDLE, 8'd1, '0, '0, 1'b0, 1'b0, 0);
		run_sequence(jss_pkg::CMD_RESET, 8'd0, '0, '0, 1'b0, 1'b0, 0);
		run_sequence(jss_pkg::CMD_IDLE, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 0);
		run_sequence(jss_pkg::CMD_IR, 8'd8, 32'h0000_00A5, '0, 1'b0, 1'b0, 0);
		run_sequence(jss_pkg::CMD_IR, 8'd0, '0, '0, 1'b0, 1'b0, 0);
		// IR shift never compares, even with a wrong expected value.
		run_sequence(jss_pkg::CMD_IR, 8'd16, 32'h1234_5678, 16'hFFFF, 1'b1, 1'b0, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd16, 32'hFFFF_FFFF, '0, 1'b1, 1'b1, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd16, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd0, '0, 16'h0000, 1'b1, 1'b0, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd0, '0, 16'hFFFF, 1'b1, 1'b0, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd255, 32'hFFFF_FFFF, '0, 1'b1, 1'b1, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd32, 32'h8000_0001, '0, 1'b0, 1'b0, 0);
		run_sequence(jss_pkg::CMD_DR, 8'd12, $urandom, '0, 1'b1, 1'b1, 40);
		send_tick(1'b0);
	endtask

	task automatic test_backpressure();
		wait_drained();
		tx_idle_on = 1'b0;
		rx_hold_req = 200;
		run_sequence(jss_pkg::CMD_DR, 8'd32, $urandom, '0, 1'b1, 1'b1, 0);
		run_sequence(jss_pkg::CMD_IDLE, 8'd20, '0, '0, 1'b0, 1'b0, 0);
		// Hold the sender back until the receiver has taken everything.
		wait_drained();
		tx_idle_on = 1'b1;
		run_sequence(jss_pkg::CMD_IR, 8'd5, $urandom, '0, 1'b0, 1'b0, 10);
	endtask

	task automatic test_random();
		int         pick;
		logic [2:0] cmd;
		logic [7:0] cnt;
		logic       chk;
		while (words_sent < WORD_GOAL) begin
			if ($urandom_range(0, 7) == 0) begin
				tx_idle_on = 1'($urandom);
				rx_idle_on = 1'($urandom);
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) send_stray();
			end else begin
				pick = $urandom_range(0, 99);
				cmd = (pick < 4) ? jss_pkg::CMD_RESET : (pick < 30) ? jss_pkg::CMD_IDLE :
					(pick < 62) ? jss_pkg::CMD_IR : jss_pkg::CMD_DR;
				pick = $urandom_range(0, 99);
				if (cmd == jss_pkg::CMD_IDLE)
					cnt = (pick < 4) ? 8'd0 : (pick < 7) ? 8'($urandom) :
						8'($urandom_range(1, 12));
				else
					cnt = (pick < 5) ? 8'd0 : (pick < 85) ? 8'($urandom_range(1, 32)) :
						8'($urandom_range(33, 255));
				chk = 1'($urandom);
				run_sequence(cmd, cnt, $urandom, 16'($urandom), chk,
					chk && $urandom_range(0, 1), ($urandom_range(0, 1) == 0) ? 0 : 10);
			end
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left != 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else if (rx_gap_left != 0) begin
			m_tready <= 1'b0;
			rx_gap_left--;
		end else begin
			m_tready <= 1'b1;
			if (rx_idle_on && $urandom_range(0, 3) == 0)
				rx_gap_left = pick_gap();
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			if (errors < 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		jss_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pulse_expect_q.size() == 0) begin
				if (errors < 10)
					$display("unexpected result word %h last %b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pulse_expect_q.pop_front();
				check_field("pulse_valid", want.pulse_valid, m_tdata[0]);
				check_field("tms_level", want.tms_level, m_tdata[1]);
				check_field("tdi_level", want.tdi_level, m_tdata[2]);
				check_field("sequence_done", want.sequence_done, m_tlast);
				check_field("captured_word", want.captured_word, m_tdata[18:3]);
				check_field("compare_mismatch", want.compare_mismatch, m_tdata[19]);
				check_field("command_rejected", want.command_rejected, m_tdata[20]);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0 && pulse_expect_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
